>>> rtl/core/ttw_pkg.sv
// shared types, constants and command/status structs of the text terminal writer
`default_nettype none

package ttw_pkg;

    // screen geometry defaults
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths of the stream beats
    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // character codes
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;
    localparam int TAB_STEP = 8;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CH_NEWLINE,
        CH_BACKSPACE,
        CH_CR,
        CH_TAB,
        CH_PRINT,
        CH_OTHER
    } char_class_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CLEAR,
        ST_NEWLINE,
        ST_SCROLL,
        ST_SCROLL_TAIL,
        ST_BLANK_ROW,
        ST_BLANK,
        ST_TAB,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC,
        CNT_LAST_ROW
    } cnt_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHAR,
        WR_BLANK_CURSOR,
        WR_FILL_RESET,
        WR_FILL_COLOR,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CELL,
        RD_SCROLL
    } rd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_COL_ZERO,
        CUR_COL_INC,
        CUR_BACK,
        CUR_ROW_INC
    } cur_op_t;

    typedef struct packed {
        cnt_op_t cnt_op;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        cur_op_t cur_op;
        logic    load_req;
        logic    capture_data;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_t        req_type;
        char_class_t char_class;
        logic        read_in_range;
        logic        at_home;
        logic        row_last;
        logic        col_last;
        logic        tab_wraps;
        logic        tab_end;
        logic        cnt_last;
        logic        cnt_scroll_last;
        logic        out_free;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/ttw_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ttw_datapath.sv
// cursor, color, sweep counter, screen ram and output beat register
`default_nettype none

module ttw_datapath #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ttw_pkg::cmd_t                  cmd,
    output ttw_pkg::status_t                    sts,
    input  wire logic [ttw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [ttw_pkg::REQ_W-1:0]      s_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [ttw_pkg::COLOR_W-1:0]    cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ttw_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST   = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] LAST_ROW_AT = AW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

    // request latch
    ttw_pkg::req_t                     req_reg;
    logic [ttw_pkg::CHAR_W-1:0]        char_reg;
    logic [ttw_pkg::INDEX_W-1:0]       index_reg;

    logic [RW-1:0]                     row_reg, row_next;
    logic [CW-1:0]                     col_reg, col_next;
    logic [AW-1:0]                     cnt_reg, cnt_next;
    logic [ttw_pkg::COLOR_W-1:0]       color_reg;
    logic [ttw_pkg::CELL_W-1:0]        data_reg;
    logic                              copy_valid_reg;
    logic [AW-1:0]                     copy_addr_reg;
    logic                              m_tvalid_reg;
    logic [ttw_pkg::M_TDATA_W-1:0]     m_tdata_reg;

    logic [AW-1:0]                     cur_addr;
    logic [31:0]                       index_ext;
    logic [CW:0]                       tab_stop;
    ttw_pkg::char_class_t              char_class;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [ttw_pkg::CELL_W-1:0]        ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [ttw_pkg::CELL_W-1:0]        ram_rdata;

    logic [31:0]                       row_ext;
    logic [31:0]                       col_ext;
    logic [31:0]                       pos_ext;

    assign cur_addr  = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign index_ext = 32'(index_reg);
    assign tab_stop  = ({1'b0, col_reg} + (CW+1)'(ttw_pkg::TAB_STEP))
                       & ~(CW+1)'(ttw_pkg::TAB_STEP - 1);

    always_comb begin
        if (char_reg == ttw_pkg::CODE_LF) begin
            char_class = ttw_pkg::CH_NEWLINE;
        end else if (char_reg == ttw_pkg::CODE_BS) begin
            char_class = ttw_pkg::CH_BACKSPACE;
        end else if (char_reg == ttw_pkg::CODE_CR) begin
            char_class = ttw_pkg::CH_CR;
        end else if (char_reg == ttw_pkg::CODE_TAB) begin
            char_class = ttw_pkg::CH_TAB;
        end else if (char_reg >= ttw_pkg::PRINT_LO && char_reg <= ttw_pkg::PRINT_HI) begin
            char_class = ttw_pkg::CH_PRINT;
        end else begin
            char_class = ttw_pkg::CH_OTHER;
        end
    end

    always_comb begin
        sts.req_type        = req_reg;
        sts.char_class      = char_class;
        sts.read_in_range   = index_ext < 32'(CELLS);
        sts.at_home         = (row_reg == '0) && (col_reg == '0);
        sts.row_last        = row_reg == LAST_ROW;
        sts.col_last        = col_reg == LAST_COL;
        sts.tab_wraps       = tab_stop >= (CW+1)'(COLUMNS);
        sts.tab_end         = col_reg[2:0] == 3'b111;
        sts.cnt_last        = cnt_reg == LAST_CELL;
        sts.cnt_scroll_last = cnt_reg == COPY_LAST;
        sts.out_free        = !m_tvalid_reg || m_tready;
    end

    // cursor and sweep counter
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        unique case (cmd.cur_op)
            ttw_pkg::CUR_HOLD: begin
            end
            ttw_pkg::CUR_HOME: begin
                row_next = '0;
                col_next = '0;
            end
            ttw_pkg::CUR_COL_ZERO: begin
                col_next = '0;
            end
            ttw_pkg::CUR_COL_INC: begin
                col_next = col_reg + CW'(1);
            end
            ttw_pkg::CUR_BACK: begin
                if (col_reg != '0) begin
                    col_next = col_reg - CW'(1);
                end else begin
                    row_next = row_reg - RW'(1);
                    col_next = LAST_COL;
                end
            end
            ttw_pkg::CUR_ROW_INC: begin
                row_next = row_reg + RW'(1);
                col_next = '0;
            end
            default: begin
            end
        endcase

        cnt_next = cnt_reg;
        unique case (cmd.cnt_op)
            ttw_pkg::CNT_HOLD:     cnt_next = cnt_reg;
            ttw_pkg::CNT_ZERO:     cnt_next = '0;
            ttw_pkg::CNT_INC:      cnt_next = cnt_reg + AW'(1);
            ttw_pkg::CNT_LAST_ROW: cnt_next = LAST_ROW_AT;
            default:               cnt_next = cnt_reg;
        endcase
    end

    // ram ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {color_reg, ttw_pkg::BLANK_CHAR};
        unique case (cmd.wr_sel)
            ttw_pkg::WR_NONE: begin
            end
            ttw_pkg::WR_CHAR: begin
                ram_we    = 1'b1;
                ram_wdata = {color_reg, char_reg};
            end
            ttw_pkg::WR_BLANK_CURSOR: begin
                ram_we = 1'b1;
            end
            ttw_pkg::WR_FILL_RESET: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = {ttw_pkg::RESET_COLOR, ttw_pkg::BLANK_CHAR};
            end
            ttw_pkg::WR_FILL_COLOR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
            end
            ttw_pkg::WR_COPY: begin
                ram_we    = copy_valid_reg;
                ram_waddr = copy_addr_reg;
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase

        ram_re    = cmd.rd_sel != ttw_pkg::RD_NONE;
        ram_raddr = (cmd.rd_sel == ttw_pkg::RD_SCROLL) ? cnt_reg + COLS_A
                                                       : index_ext[AW-1:0];
    end

    ttw_ram #(
        .WIDTH (ttw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);
    assign pos_ext = 32'(cur_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            cnt_reg        <= '0;
            color_reg      <= ttw_pkg::RESET_COLOR;
            copy_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            cnt_reg        <= cnt_next;
            copy_valid_reg <= cmd.rd_sel == ttw_pkg::RD_SCROLL;
            if (cfg_we) begin
                color_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= cnt_reg;
        if (cmd.load_req) begin
            req_reg   <= ttw_pkg::req_t'(s_tuser);
            char_reg  <= s_tdata[ttw_pkg::CHAR_W-1:0];
            index_reg <= s_tdata[ttw_pkg::CHAR_W +: ttw_pkg::INDEX_W];
            data_reg  <= '0;
        end else if (cmd.capture_data) begin
            data_reg  <= ram_rdata;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= ttw_pkg::M_TDATA_W'({data_reg,
                                                pos_ext[ttw_pkg::POS_OUT_W-1:0],
                                                col_ext[ttw_pkg::COL_OUT_W-1:0],
                                                row_ext[ttw_pkg::ROW_OUT_W-1:0]});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // cursor stays on the screen
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("cursor left the screen");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending beat");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ttw_ctrl.sv
// request sequencer of the text terminal writer
`default_nettype none

module ttw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire ttw_pkg::status_t sts,
    output ttw_pkg::cmd_t         cmd
);

    ttw_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttw_pkg::ST_INIT: begin
                if (sts.cnt_last) begin
                    state_next = ttw_pkg::ST_IDLE;
                end
            end
            ttw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ttw_pkg::ST_DECODE;
                end
            end
            ttw_pkg::ST_DECODE: begin
                unique case (sts.req_type)
                    ttw_pkg::REQ_READ:  state_next = ttw_pkg::ST_READ;
                    ttw_pkg::REQ_CLEAR: state_next = ttw_pkg::ST_CLEAR;
                    ttw_pkg::REQ_NONE:  state_next = ttw_pkg::ST_DONE;
                    ttw_pkg::REQ_PUT: begin
                        unique case (sts.char_class)
                            ttw_pkg::CH_NEWLINE:   state_next = ttw_pkg::ST_NEWLINE;
                            ttw_pkg::CH_BACKSPACE: state_next = sts.at_home ? ttw_pkg::ST_DONE
                                                                            : ttw_pkg::ST_BLANK;
                            ttw_pkg::CH_TAB:       state_next = sts.tab_wraps ? ttw_pkg::ST_NEWLINE
                                                                              : ttw_pkg::ST_TAB;
                            ttw_pkg::CH_PRINT:     state_next = sts.col_last ? ttw_pkg::ST_NEWLINE
                                                                             : ttw_pkg::ST_DONE;
                            default:               state_next = ttw_pkg::ST_DONE;
                        endcase
                    end
                    default: state_next = ttw_pkg::ST_DONE;
                endcase
            end
            ttw_pkg::ST_READ:    state_next = ttw_pkg::ST_DONE;
            ttw_pkg::ST_CLEAR: begin
                if (sts.cnt_last) begin
                    state_next = ttw_pkg::ST_DONE;
                end
            end
            ttw_pkg::ST_NEWLINE: begin
                state_next = sts.row_last ? ttw_pkg::ST_SCROLL : ttw_pkg::ST_DONE;
            end
            ttw_pkg::ST_SCROLL: begin
                if (sts.cnt_scroll_last) begin
                    state_next = ttw_pkg::ST_SCROLL_TAIL;
                end
            end
            ttw_pkg::ST_SCROLL_TAIL: state_next = ttw_pkg::ST_BLANK_ROW;
            ttw_pkg::ST_BLANK_ROW: begin
                if (sts.cnt_last) begin
                    state_next = ttw_pkg::ST_DONE;
                end
            end
            ttw_pkg::ST_BLANK:   state_next = ttw_pkg::ST_DONE;
            ttw_pkg::ST_TAB: begin
                if (sts.tab_end) begin
                    state_next = ttw_pkg::ST_DONE;
                end
            end
            ttw_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ttw_pkg::ST_IDLE;
                end
            end
            default: state_next = ttw_pkg::ST_INIT;
        endcase
    end

    // commands
    always_comb begin
        cmd          = '0;
        cmd.cnt_op   = ttw_pkg::CNT_HOLD;
        cmd.wr_sel   = ttw_pkg::WR_NONE;
        cmd.rd_sel   = ttw_pkg::RD_NONE;
        cmd.cur_op   = ttw_pkg::CUR_HOLD;
        s_tready     = 1'b0;
        unique case (state_reg)
            ttw_pkg::ST_INIT: begin
                cmd.wr_sel = ttw_pkg::WR_FILL_RESET;
                cmd.cnt_op = ttw_pkg::CNT_INC;
            end
            ttw_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            ttw_pkg::ST_DECODE: begin
                unique case (sts.req_type)
                    ttw_pkg::REQ_READ: begin
                        if (sts.read_in_range) begin
                            cmd.rd_sel = ttw_pkg::RD_CELL;
                        end
                    end
                    ttw_pkg::REQ_CLEAR: cmd.cnt_op = ttw_pkg::CNT_ZERO;
                    ttw_pkg::REQ_NONE: begin
                    end
                    ttw_pkg::REQ_PUT: begin
                        unique case (sts.char_class)
                            ttw_pkg::CH_BACKSPACE: begin
                                if (!sts.at_home) begin
                                    cmd.cur_op = ttw_pkg::CUR_BACK;
                                end
                            end
                            ttw_pkg::CH_CR: cmd.cur_op = ttw_pkg::CUR_COL_ZERO;
                            ttw_pkg::CH_PRINT: begin
                                cmd.wr_sel = ttw_pkg::WR_CHAR;
                                if (!sts.col_last) begin
                                    cmd.cur_op = ttw_pkg::CUR_COL_INC;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
            ttw_pkg::ST_READ: begin
                cmd.capture_data = sts.read_in_range;
            end
            ttw_pkg::ST_CLEAR: begin
                cmd.wr_sel = ttw_pkg::WR_FILL_COLOR;
                cmd.cnt_op = ttw_pkg::CNT_INC;
                if (sts.cnt_last) begin
                    cmd.cur_op = ttw_pkg::CUR_HOME;
                end
            end
            ttw_pkg::ST_NEWLINE: begin
                if (sts.row_last) begin
                    cmd.cur_op = ttw_pkg::CUR_COL_ZERO;
                    cmd.cnt_op = ttw_pkg::CNT_ZERO;
                end else begin
                    cmd.cur_op = ttw_pkg::CUR_ROW_INC;
                end
            end
            ttw_pkg::ST_SCROLL: begin
                cmd.rd_sel = ttw_pkg::RD_SCROLL;
                cmd.wr_sel = ttw_pkg::WR_COPY;
                cmd.cnt_op = ttw_pkg::CNT_INC;
            end
            ttw_pkg::ST_SCROLL_TAIL: begin
                cmd.wr_sel = ttw_pkg::WR_COPY;
                cmd.cnt_op = ttw_pkg::CNT_LAST_ROW;
            end
            ttw_pkg::ST_BLANK_ROW: begin
                cmd.wr_sel = ttw_pkg::WR_FILL_COLOR;
                cmd.cnt_op = ttw_pkg::CNT_INC;
            end
            ttw_pkg::ST_BLANK: begin
                cmd.wr_sel = ttw_pkg::WR_BLANK_CURSOR;
            end
            ttw_pkg::ST_TAB: begin
                cmd.wr_sel = ttw_pkg::WR_BLANK_CURSOR;
                cmd.cur_op = ttw_pkg::CUR_COL_INC;
            end
            ttw_pkg::ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted beat is decoded on the next cycle
    a_accept_to_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttw_pkg::ST_IDLE && s_tvalid) |=> state_reg == ttw_pkg::ST_DECODE)
        else $error("accepted beat not decoded");

    // scrolling only starts from a newline on the last row
    a_scroll_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ttw_pkg::ST_SCROLL && $past(state_reg) != ttw_pkg::ST_SCROLL)
        |-> ($past(state_reg) == ttw_pkg::ST_NEWLINE && $past(sts.row_last)))
        else $error("scroll entered from wrong state");
`endif

endmodule

`default_nettype wire

>>> rtl/core/text_terminal_writer_top.sv
// top level of the character-cell text terminal writer
// each request is accepted, decoded, taken through its states and then loaded as a result
//   beat; tab pads up to 8 cells, scroll copies the screen up a row and blanks the last row
// scroll and clear walk one screen cell a cycle
// throughput: one request in flight; the next beat is taken while the result waits
// reset: synchronous active-low; afterwards a clearing pass fills the screen with blanks
//   in color 0x0F, with s_tready low; cfg writes still taken
`default_nettype none

module text_terminal_writer_top #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // char_code [7:0], cell_index [18:8], zero pad [23:19]
    input  wire logic [ttw_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type [1:0]
    input  wire logic [ttw_pkg::REQ_W-1:0]      s_tuser,

    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cursor_row [4:0], cursor_col [11:5], cursor_pos [22:12], read_data [38:23],
    // zero pad [39]
    output logic      [ttw_pkg::M_TDATA_W-1:0]  m_tdata,

    // text color register write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttw_pkg::COLOR_W-1:0]    cfg_data
);

    ttw_pkg::cmd_t    cmd;
    ttw_pkg::status_t sts;

    // the color register takes a write beat in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: walks each request through decode, sweeps and result hand-off
    ttw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // cursor, color, screen ram and the output beat register
    ttw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
